// ----- sv/bsc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the barometric compensation core.
// Used by bsc_div_pipe and baro_sensor_compensation_core; depends on nothing.
package bsc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TEMP    = 2'd0;
  localparam logic [1:0] CFG_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_C = 2'd3;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_READ_FAIL = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd2;

  // Pipelined divider geometry: 47 quotient bits, 58-bit divisor magnitude,
  // and 14 low dividend bits shifted in after the initial remainder.
  localparam int DivSteps = 47;
  localparam int RemW     = 58;
  localparam int LoW      = 14;
  localparam int QuoW     = 47;

  // Per-word side information that travels with the datapath.
  typedef struct packed {
    logic               fail;
    logic               zero;
    logic               neg;
    logic               ovf;
    logic signed [15:0] tc;
  } side_t;

endpackage

// ----- sv/bsc_div_pipe.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bsc_pkg for widths and the side_t word that rides along.
module bsc_div_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [bsc_pkg::RemW-1:0]    rem_i,
  input  logic [bsc_pkg::RemW-1:0]    div_i,
  input  logic [bsc_pkg::LoW-1:0]     lo_i,
  input  bsc_pkg::side_t              side_i,
  output logic                        vld_o,
  output logic [bsc_pkg::QuoW-1:0]    quo_o,
  output bsc_pkg::side_t              side_o
);

  localparam int N = bsc_pkg::DivSteps;
  localparam int RW = bsc_pkg::RemW;
  localparam int LW = bsc_pkg::LoW;
  localparam int QW = bsc_pkg::QuoW;

  logic           vld_q  [N];
  logic [RW-1:0]  rem_q  [N];
  logic [RW-1:0]  div_q  [N];
  logic [LW-1:0]  lo_q   [N];
  logic [QW-1:0]  quo_q  [N];
  bsc_pkg::side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic           vld_p;
    logic [RW-1:0]  rem_p;
    logic [RW-1:0]  div_p;
    logic [LW-1:0]  lo_p;
    logic [QW-1:0]  quo_p;
    bsc_pkg::side_t side_p;
    logic [RW:0]    trial;
    logic [RW+1:0]  diff;

    if (k == 0) begin : g_first
      assign vld_p  = vld_i;
      assign rem_p  = rem_i;
      assign div_p  = div_i;
      assign lo_p   = lo_i;
      assign quo_p  = '0;
      assign side_p = side_i;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign div_p  = div_q[k-1];
      assign lo_p   = lo_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign side_p = side_q[k-1];
    end

    // Bring down the next dividend bit and try one subtraction.
    assign trial = {rem_p, lo_p[LW-1]};
    assign diff  = {1'b0, trial} - {2'b00, div_p};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= diff[RW+1] ? trial[RW-1:0] : diff[RW-1:0];
        div_q[k]  <= div_p;
        lo_q[k]   <= {lo_p[LW-2:0], 1'b0};
        quo_q[k]  <= {quo_p[QW-2:0], ~diff[RW+1]};
        side_q[k] <= side_p;
      end
    end
  end

  assign vld_o  = vld_q[N-1];
  assign quo_o  = quo_q[N-1];
  assign side_o = side_q[N-1];

endmodule

// ----- sv/baro_sensor_compensation_core.sv -----
`timescale 1ns / 1ps
// Barometric pressure and temperature compensation core, top level.
// Depends on bsc_pkg and bsc_div_pipe.
//
// Usage: the input channel (in_valid_i / in_stall_o) takes one word per
// cycle while in_stall_o is low: raw pressure, raw temperature and a
// read-failure flag. The output channel (out_valid_o / out_stall_i) returns
// one word per input word, in order: temperature in 0.01 degC, pressure in
// Pa with 8 fraction bits, and a status code. Calibration words are written
// through cfg_we_i, cfg_index_i and cfg_data_i while no word is in flight.
// Throughput is one word per clock while the skid register is empty. The
// pipeline has 14 front stages (multiplies split into partial products),
// the 47-stage divider with one quotient bit per stage, and 6 trim stages.
// The output register is backed by a one-word skid register. When the
// receiver stalls, the word behind the waiting result is caught in the skid
// register and the whole pipeline then holds; in_stall_o follows the skid
// register, so no word is lost or repeated.
// Reset clears all valid bits and the calibration registers to zero.
module baro_sensor_compensation_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [19:0]        raw_pressure_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic               read_failed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] temperature_centi_o,
  output logic [31:0]        pressure_q8_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam logic signed [57:0] GOfs = 58'sd2199023255552000;

  // Calibration registers.
  logic [47:0]        temp_q;
  logic [63:0]        press_a_q;
  logic [63:0]        press_b_q;
  logic [15:0]        press_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q    <= '0;
      press_a_q <= '0;
      press_b_q <= '0;
      press_c_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsc_pkg::CFG_TEMP:    temp_q    <= cfg_data_i[47:0];
        bsc_pkg::CFG_PRESS_A: press_a_q <= cfg_data_i;
        bsc_pkg::CFG_PRESS_B: press_b_q <= cfg_data_i;
        bsc_pkg::CFG_PRESS_C: press_c_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [15:0]        p8mag, p9mag;

  assign t1 = temp_q[15:0];
  assign t2 = $signed(temp_q[31:16]);
  assign t3 = $signed(temp_q[47:32]);
  assign p1 = press_a_q[15:0];
  assign p2 = $signed(press_a_q[31:16]);
  assign p3 = $signed(press_a_q[47:32]);
  assign p4 = $signed(press_a_q[63:48]);
  assign p5 = $signed(press_b_q[15:0]);
  assign p6 = $signed(press_b_q[31:16]);
  assign p7 = $signed(press_b_q[47:32]);
  assign p8 = $signed(press_b_q[63:48]);
  assign p9 = $signed(press_c_q);
  assign p8mag = p8[15] ? 16'(-p8) : p8;
  assign p9mag = p9[15] ? 16'(-p9) : p9;

  // Pipeline advance: everything moves unless the skid register is full.
  logic en;
  logic skid_vld_q;
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  logic [14:1] vf_q;
  logic [6:1]  vb_q;
  logic        dv_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
      vb_q <= '0;
    end else if (en) begin
      vf_q <= {vf_q[13:1], in_valid_i};
      vb_q <= {vb_q[5:1], dv_vld};
    end
  end

  // ---------------- Front stages: fine temperature, numerator and divisor terms
  bsc_pkg::side_t     sd_q [1:14];
  bsc_pkg::side_t     sd1_d, sd5_d, sd13_d, sd14_d;

  logic signed [20:0] a_d, a1_q;
  logic [19:0]        pr1_q, pr2_q, pr3_q, pr4_q, pr5_q, pr6_q;
  logic signed [41:0] aa_full;
  logic signed [36:0] at2_q;
  logic [40:0]        aa_q;
  logic signed [57:0] f_d, f_q;
  logic signed [60:0] f_x, f5_d, f5_q;
  logic signed [57:0] g_d, g_q;
  logic [60:0]        t_sum;
  logic signed [18:0] tcr;
  logic signed [15:0] tc_d;
  logic [57:0]        g_neg;
  logic [56:0]        gm_d, gm_q;
  logic signed [73:0] gp5_q, gp2_q;
  logic [55:0]        hh_q;
  logic [56:0]        hl_q;
  logic [57:0]        ll_q;
  logic [73:0]        s5_sum, s2_sum;
  logic signed [41:0] r5_q;
  logic signed [36:0] r2_q;
  logic [114:0]       gg_d, gg_q, v2_sum;
  logic [20:0]        prc;
  logic signed [47:0] base_d, base_q, base8_q, base9_q, base10_q;
  logic signed [39:0] dp_d, dp_q, dp8_q, dp9_q, dp10_q;
  logic [62:0]        v2_q;
  logic signed [79:0] v6_q, v3_q;
  logic [79:0]        v6_sum, v3_sum;
  logic signed [48:0] r6_q;
  logic signed [40:0] r3_q;
  logic signed [49:0] b16_q;
  logic signed [41:0] d32_q;
  logic signed [63:0] n_q;
  logic signed [58:0] dd_q;
  logic [63:0]        n_neg;
  logic [58:0]        dd_neg;
  logic [62:0]        un_d, un_q;
  logic [57:0]        ud_d, ud_q, ud14_q, rem0_q;
  logic [13:0]        lo_q;

  always_comb begin
    a_d     = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, t1, 4'b0000});
    sd1_d   = '{fail: read_failed_i, zero: 1'b0, neg: 1'b0, ovf: 1'b0, tc: 16'sd0};
    aa_full = a1_q * a1_q;
    f_d     = (58'(at2_q) <<< 20) + ($signed({1'b0, aa_q}) * t3);
    f_x     = 61'(f_q);
    f5_d    = (f_x <<< 2) + f_x;
    g_d     = f_q - GOfs;

    // Round half away from zero: add half, minus one when negative.
    t_sum = f5_q + 61'sd2199023255552 - 61'(f5_q[60]);
    tcr   = $signed(t_sum[60:42]);
    if (tcr > 19'sd32767) begin
      tc_d = 16'sh7fff;
    end else if (tcr < -19'sd32768) begin
      tc_d = 16'sh8000;
    end else begin
      tc_d = tcr[15:0];
    end
    sd5_d    = sd_q[4];
    sd5_d.tc = tc_d;

    g_neg = -g_q;
    gm_d  = g_q[57] ? g_neg[56:0] : g_q[56:0];

    s5_sum = gp5_q + 74'sd2147483648 - 74'(gp5_q[73]);
    s2_sum = gp2_q + 74'sd68719476736 - 74'(gp2_q[73]);

    // The square of |G| from three partial products of 28/29-bit halves.
    gg_d   = (115'(hh_q) << 58) + (115'(hl_q) << 30) + 115'(ll_q);
    prc    = 21'h100000 - {1'b0, pr6_q};
    base_d = $signed({11'b0, prc, 16'b0}) - (48'(p4) <<< 20) - 48'(r5_q);
    dp_d   = 40'sh1_0000_0000 + 40'(r2_q);

    v2_sum = gg_q + (115'(1) << 51);
    v6_sum = v6_q + 80'sd1073741824 - 80'(v6_q[79]);
    v3_sum = v3_q + 80'sd274877906944 - 80'(v3_q[79]);

    n_neg  = -n_q;
    dd_neg = -dd_q;
    un_d   = n_q[63] ? n_neg[62:0] : n_q[62:0];
    ud_d   = dd_q[58] ? dd_neg[57:0] : dd_q[57:0];
    sd13_d      = sd_q[12];
    sd13_d.neg  = n_q[63] ^ dd_q[58];
    sd13_d.zero = (dd_q == '0);

    // Quotient of 2^14 or more saturates; this also keeps the remainder
    // of the divider below the divisor.
    sd14_d     = sd_q[13];
    sd14_d.ovf = (72'(un_q) >= {ud_q, 14'b0});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= a_d;
      pr1_q <= raw_pressure_i;
      at2_q <= a1_q * t2;
      aa_q  <= aa_full[40:0];
      pr2_q <= pr1_q;
      f_q   <= f_d;
      pr3_q <= pr2_q;
      f5_q  <= f5_d;
      g_q   <= g_d;
      pr4_q <= pr3_q;
      gm_q  <= gm_d;
      gp5_q <= g_q * p5;
      gp2_q <= g_q * p2;
      pr5_q <= pr4_q;
      hh_q  <= gm_q[56:29] * gm_q[56:29];
      hl_q  <= gm_q[56:29] * gm_q[28:0];
      ll_q  <= gm_q[28:0] * gm_q[28:0];
      r5_q  <= $signed(s5_sum[73:32]);
      r2_q  <= $signed(s2_sum[73:37]);
      pr6_q <= pr5_q;
      gg_q  <= gg_d;
      base_q <= base_d;
      dp_q   <= dp_d;
      v2_q    <= v2_sum[114:52];
      base8_q <= base_q;
      dp8_q   <= dp_q;
      v6_q    <= $signed({1'b0, v2_q}) * p6;
      v3_q    <= $signed({1'b0, v2_q}) * p3;
      base9_q <= base8_q;
      dp9_q   <= dp8_q;
      r6_q     <= $signed(v6_sum[79:31]);
      r3_q     <= $signed(v3_sum[79:39]);
      base10_q <= base9_q;
      dp10_q   <= dp9_q;
      b16_q <= 50'(base10_q) - 50'(r6_q);
      d32_q <= 42'(dp10_q) + 42'(r3_q);
      n_q   <= b16_q * 64'sd6250;
      dd_q  <= d32_q * $signed({1'b0, p1});
      un_q  <= un_d;
      ud_q  <= ud_d;
      rem0_q <= {9'b0, un_q[62:14]};
      ud14_q <= ud_q;
      lo_q   <= un_q[13:0];

      sd_q[1] <= sd1_d;
      for (int k = 2; k <= 14; k++) begin
        if (k == 5) begin
          sd_q[k] <= sd5_d;
        end else if (k == 13) begin
          sd_q[k] <= sd13_d;
        end else if (k == 14) begin
          sd_q[k] <= sd14_d;
        end else begin
          sd_q[k] <= sd_q[k-1];
        end
      end
    end
  end

  // ---------------- Division: p16 = round(B16 * 6250 * 2^32 / dd) ----------
  logic [bsc_pkg::QuoW-1:0] dq;
  bsc_pkg::side_t           dsd;

  bsc_div_pipe u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vf_q[14]),
    .rem_i  (rem0_q),
    .div_i  (ud14_q),
    .lo_i   (lo_q),
    .side_i (sd_q[14]),
    .vld_o  (dv_vld),
    .quo_o  (dq),
    .side_o (dsd)
  );

  // ---------------- Trim stages ----------------------------------------------
  bsc_pkg::side_t     sdb_q [1:6];
  logic [47:0]        qr_sum;
  logic [46:0]        m_d, m1_q, m2_q;
  logic [62:0]        xm_q, c8m_q;
  logic [54:0]        phh_q;
  logic [55:0]        phl_q;
  logic [53:0]        plh_q;
  logic [54:0]        pll_q;
  logic [63:0]        c8_sum;
  logic [48:0]        c8r_q;
  logic signed [47:0] ps_d, ps3_q, ps4_q, ps5_q;
  logic [109:0]       sum_d, sum_q;
  logic signed [49:0] c8s_d, c8s_q, c8s5_q;
  logic [110:0]       c9_sum;
  logic [61:0]        c9mag;
  logic signed [62:0] c9s_d, c9s_q;
  logic signed [63:0] s_d, s_q;

  always_comb begin
    // Quotient carries one extra bit for rounding; saturate at 2^46.
    qr_sum = {1'b0, dq} + 48'd1;
    if (dsd.ovf || (qr_sum[47:1] > (47'(1) << 46))) begin
      m_d = 47'(1) << 46;
    end else begin
      m_d = qr_sum[47:1];
    end

    c8_sum = 64'(c8m_q) + 64'd16384;
    ps_d   = sdb_q[2].neg ? -$signed({1'b0, m2_q}) : $signed({1'b0, m2_q});

    sum_d = (110'(phh_q) << 55) + (110'(phl_q) << 31) + (110'(plh_q) << 24)
            + 110'(pll_q);
    c8s_d = (sdb_q[3].neg ^ p8[15]) ? -$signed({1'b0, c8r_q}) : $signed({1'b0, c8r_q});

    c9_sum = 111'(sum_q) + (111'(1) << 46);
    c9mag  = c9_sum[108:47];
    c9s_d  = p9[15] ? -$signed({1'b0, c9mag}) : $signed({1'b0, c9mag});

    s_d = (64'(ps5_q) <<< 4) + 64'(c9s_q) + 64'(c8s5_q) + (64'(p7) <<< 16);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q   <= m_d;
      xm_q   <= m1_q * p9mag;
      c8m_q  <= m1_q * p8mag;
      m2_q   <= m1_q;
      phh_q  <= xm_q[62:31] * m2_q[46:24];
      phl_q  <= xm_q[62:31] * m2_q[23:0];
      plh_q  <= xm_q[30:0] * m2_q[46:24];
      pll_q  <= xm_q[30:0] * m2_q[23:0];
      c8r_q  <= c8_sum[63:15];
      ps3_q  <= ps_d;
      sum_q  <= sum_d;
      c8s_q  <= c8s_d;
      ps4_q  <= ps3_q;
      c9s_q  <= c9s_d;
      c8s5_q <= c8s_q;
      ps5_q  <= ps4_q;
      s_q    <= s_d;
      sdb_q[1] <= dsd;
      for (int k = 2; k <= 6; k++) begin
        sdb_q[k] <= sdb_q[k-1];
      end
    end
  end

  // Final rounding to 8 fraction bits and saturation of the result word.
  logic [63:0]        fin_sum;
  logic [51:0]        fin_t;
  logic [31:0]        pq_sat;
  logic signed [15:0] res_tc;
  logic [31:0]        res_pq;
  logic [1:0]         res_st;

  always_comb begin
    fin_sum = s_q + 64'sd2048;
    fin_t   = fin_sum[63:12];
    if (s_q[63]) begin
      pq_sat = '0;
    end else if (fin_t[51:32] != '0) begin
      pq_sat = '1;
    end else begin
      pq_sat = fin_t[31:0];
    end

    if (sdb_q[6].fail) begin
      res_tc = '0;
      res_pq = '0;
      res_st = bsc_pkg::ST_READ_FAIL;
    end else if (sdb_q[6].zero) begin
      res_tc = sdb_q[6].tc;
      res_pq = '0;
      res_st = bsc_pkg::ST_DIV_ZERO;
    end else begin
      res_tc = sdb_q[6].tc;
      res_pq = pq_sat;
      res_st = bsc_pkg::ST_OK;
    end
  end

  // ---------------- Output register with skid word ---------------------------
  logic               out_vld_q, out_vld_d, skid_vld_d;
  logic               take, incoming, ld_new, ld_skid_out, ld_skid;
  logic signed [15:0] out_tc_q, skid_tc_q;
  logic [31:0]        out_pq_q, skid_pq_q;
  logic [1:0]         out_st_q, skid_st_q;

  always_comb begin
    take        = out_vld_q && !out_stall_i;
    incoming    = en && vb_q[6];
    out_vld_d   = out_vld_q;
    skid_vld_d  = skid_vld_q;
    ld_new      = 1'b0;
    ld_skid_out = 1'b0;
    ld_skid     = 1'b0;
    if (skid_vld_q) begin
      if (take) begin
        ld_skid_out = 1'b1;
        skid_vld_d  = 1'b0;
      end
    end else if (incoming) begin
      if (!out_vld_q || take) begin
        ld_new    = 1'b1;
        out_vld_d = 1'b1;
      end else begin
        ld_skid    = 1'b1;
        skid_vld_d = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_new) begin
      out_tc_q <= res_tc;
      out_pq_q <= res_pq;
      out_st_q <= res_st;
    end else if (ld_skid_out) begin
      out_tc_q <= skid_tc_q;
      out_pq_q <= skid_pq_q;
      out_st_q <= skid_st_q;
    end
    if (ld_skid) begin
      skid_tc_q <= res_tc;
      skid_pq_q <= res_pq;
      skid_st_q <= res_st;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign temperature_centi_o = out_tc_q;
  assign pressure_q8_o       = out_pq_q;
  assign status_o            = out_st_q;

endmodule
